>>> rtl/bpc_pkg.sv
// Shared types and constants for the bitplane row to chunky pixel converter.
`timescale 1ns / 1ps
package bpc_pkg;

    localparam int GROUP_PIXELS = 16;
    localparam int PLANE_BYTES  = 16;
    localparam int IDX_W        = $clog2(GROUP_PIXELS);

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_DEPTH = 2'd0;
    localparam logic [1:0] CFG_LAYOUT_MODE = 2'd1;
    localparam logic [1:0] CFG_INVERT_MONO = 2'd2;

    // layout codes
    localparam logic [1:0] LAYOUT_PLANAR = 2'd0;
    localparam logic [1:0] LAYOUT_BYTE   = 2'd1;
    localparam logic [1:0] LAYOUT_PACKED = 2'd2;
    localparam logic [1:0] LAYOUT_NONE   = 2'd3;

    // direct color depths
    localparam logic [5:0] DEPTH_RGB565 = 6'd16;
    localparam logic [5:0] DEPTH_RGB24  = 6'd24;
    localparam logic [5:0] DEPTH_XRGB32 = 6'd32;

    typedef enum logic [2:0] {
        K_BAD,
        K_COPY,
        K_PACK,
        K_RGB,
        K_PLANE
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic             has_out;
        logic [IDX_W-1:0] last_idx;
    } t_dp_sts;

endpackage

>>> rtl/bpc_in_if.sv
// Input channel: source bytes of an image row.
`timescale 1ns / 1ps
interface bpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       row_start;

    modport source (output valid, output source_byte, output row_start, input ready);
    modport sink   (input valid, input source_byte, input row_start, output ready);
endinterface

>>> rtl/bpc_out_if.sv
// Output channel: chunky pixel bytes.
`timescale 1ns / 1ps
interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       last_of_item;
    logic       bad_format;

    modport source (output valid, output pixel_value, output last_of_item,
                    output bad_format, input ready);
    modport sink   (input valid, input pixel_value, input last_of_item,
                    input bad_format, output ready);
endinterface

>>> rtl/bpc_datapath.sv
// Datapath: config registers, format decode, plane byte store and pixel select.
`timescale 1ns / 1ps
module bpc_datapath #(
    parameter int MAX_PLANES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [5:0]               i_cfg_data,
    input  logic [7:0]               i_source_byte,
    input  logic                     i_row_start,
    input  bpc_pkg::t_dp_cmd         i_cmd,
    output bpc_pkg::t_dp_sts         o_sts,
    output logic [7:0]               o_pixel_value,
    output logic                     o_bad_format
);

    localparam int IW = bpc_pkg::IDX_W;

    // configuration
    logic [5:0] r_depth;
    logic [1:0] r_layout;
    logic       r_invert;

    // item state
    logic [IW-1:0]      r_gp, n_gp;
    bpc_pkg::t_kind     r_kind, n_kind;
    logic [7:0]         r_byte;
    logic [1:0]         r_plog, n_plog;
    logic [7:0]         r_pmask, n_pmask;
    logic [7:0]         r_plane [bpc_pkg::PLANE_BYTES];

    logic [IW-1:0] gp_eff;
    logic [7:0]    b_eff;
    logic          is_rgb, is_small, is_pow2, fmt_bad;
    logic          plane_we, has_out;
    logic [IW-1:0] last_idx;
    logic [15:0]   w_plane [8];
    logic [7:0]    pl_pix, pack_pix, rgb_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= 6'd1;
            r_layout <= bpc_pkg::LAYOUT_PLANAR;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::CFG_PIXEL_DEPTH: r_depth  <= i_cfg_data;
                bpc_pkg::CFG_LAYOUT_MODE: r_layout <= i_cfg_data[1:0];
                bpc_pkg::CFG_INVERT_MONO: r_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode of the incoming word
    always_comb begin
        gp_eff   = i_row_start ? '0 : r_gp;
        b_eff    = (r_depth == 6'd1 && r_invert) ? ~i_source_byte : i_source_byte;
        is_rgb   = (r_depth == bpc_pkg::DEPTH_RGB565) || (r_depth == bpc_pkg::DEPTH_RGB24)
                   || (r_depth == bpc_pkg::DEPTH_XRGB32);
        is_small = (r_depth >= 6'd1) && (r_depth <= 6'd8);
        is_pow2  = (r_depth == 6'd1) || (r_depth == 6'd2) || (r_depth == 6'd4)
                   || (r_depth == 6'd8);
        fmt_bad  = !is_rgb && (!is_small || (r_layout == bpc_pkg::LAYOUT_NONE)
                   || (r_layout == bpc_pkg::LAYOUT_PACKED && !is_pow2)
                   || (r_layout == bpc_pkg::LAYOUT_PLANAR && r_depth > 6'd1
                       && r_depth > 6'(MAX_PLANES)));

        for (int p = 0; p < 8; p++) begin
            n_pmask[p] = 6'(p) < r_depth;
        end
        unique case (r_depth)
            6'd2:    n_plog = 2'd1;
            6'd4:    n_plog = 2'd2;
            6'd8:    n_plog = 2'd3;
            default: n_plog = 2'd0;
        endcase

        n_gp     = gp_eff;
        n_kind   = bpc_pkg::K_BAD;
        plane_we = 1'b0;
        has_out  = 1'b1;
        last_idx = '0;
        if (fmt_bad) begin
            n_kind = bpc_pkg::K_BAD;
        end else if (is_small) begin
            if (r_layout == bpc_pkg::LAYOUT_BYTE) begin
                n_kind = bpc_pkg::K_COPY;
                n_gp   = '0;
            end else if (r_layout == bpc_pkg::LAYOUT_PACKED || r_depth == 6'd1) begin
                n_kind   = bpc_pkg::K_PACK;
                last_idx = IW'(4'd7 >> n_plog);
                n_gp     = '0;
            end else begin
                n_kind   = bpc_pkg::K_PLANE;
                plane_we = 1'b1;
                if (({1'b0, gp_eff} + 5'd1) >= {r_depth[3:0], 1'b0}) begin
                    last_idx = IW'(bpc_pkg::GROUP_PIXELS - 1);
                    n_gp     = '0;
                end else begin
                    has_out = 1'b0;
                    n_gp    = gp_eff + 1'b1;
                end
            end
        end else if (r_depth == bpc_pkg::DEPTH_RGB565) begin
            n_kind = bpc_pkg::K_RGB;
            if (gp_eff == '0) begin
                // high byte of the word goes to plane store entry zero
                plane_we = 1'b1;
                has_out  = 1'b0;
                n_gp     = IW'(1);
            end else begin
                last_idx = IW'(2);
                n_gp     = '0;
            end
        end else if (r_depth == bpc_pkg::DEPTH_RGB24) begin
            n_kind = bpc_pkg::K_COPY;
            n_gp   = '0;
        end else begin
            n_kind = bpc_pkg::K_COPY;
            if (gp_eff == '0) begin
                has_out = 1'b0;   // pad byte
                n_gp    = IW'(1);
            end else begin
                n_gp = (gp_eff >= IW'(3)) ? '0 : gp_eff + 1'b1;
            end
        end
    end

    assign o_sts.has_out  = has_out;
    assign o_sts.last_idx = last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp   <= '0;
            r_kind <= bpc_pkg::K_BAD;
        end else if (i_cmd.load) begin
            r_gp   <= n_gp;
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= b_eff;
            r_plog  <= n_plog;
            r_pmask <= n_pmask;
            if (plane_we) begin
                r_plane[gp_eff] <= b_eff;
            end
        end else if (i_cmd.step && r_kind == bpc_pkg::K_PACK) begin
            r_byte <= r_byte << (4'd1 << r_plog);
        end
    end

    // pixel select
    always_comb begin
        for (int p = 0; p < 8; p++) begin
            w_plane[p] = {r_plane[2 * p], r_plane[2 * p + 1]};
        end
        pl_pix = '0;
        for (int p = 0; p < MAX_PLANES; p++) begin
            pl_pix[p] = r_pmask[p] & w_plane[p][4'd15 - i_cmd.idx];
        end

        unique case (r_plog)
            2'd0:    pack_pix = {7'b0, r_byte[7]};
            2'd1:    pack_pix = {6'b0, r_byte[7:6]};
            2'd2:    pack_pix = {4'b0, r_byte[7:4]};
            default: pack_pix = r_byte;
        endcase

        unique case (i_cmd.idx[1:0])
            2'd0:    rgb_pix = {r_plane[0][7:3], 3'b0};
            2'd1:    rgb_pix = {r_plane[0][2:0], r_byte[7:5], 2'b0};
            default: rgb_pix = {r_byte[4:0], 3'b0};
        endcase

        unique case (r_kind)
            bpc_pkg::K_COPY:  o_pixel_value = r_byte;
            bpc_pkg::K_PACK:  o_pixel_value = pack_pix;
            bpc_pkg::K_RGB:   o_pixel_value = rgb_pix;
            bpc_pkg::K_PLANE: o_pixel_value = pl_pix;
            default:          o_pixel_value = '0;
        endcase
    end

    assign o_bad_format = (r_kind == bpc_pkg::K_BAD);

endmodule

>>> rtl/bpc_ctrl.sv
// Controller: accepts input words and sequences the results of each one.
`timescale 1ns / 1ps
module bpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_out_last,
    input  bpc_pkg::t_dp_sts i_sts,
    output bpc_pkg::t_dp_cmd o_cmd
);

    localparam int IW = bpc_pkg::IDX_W;

    bpc_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_k, n_k;
    logic [IW-1:0]   r_last, n_last;
    logic            out_fire, at_last, load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpc_pkg::ST_IDLE;
            r_k     <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_last  <= n_last;
        end
    end

    always_comb begin
        out_fire   = (r_state == bpc_pkg::ST_EMIT) && i_out_ready;
        at_last    = (r_k == r_last);
        // next word may enter on the cycle the last result leaves
        o_in_ready = (r_state == bpc_pkg::ST_IDLE) || (out_fire && at_last);
        load       = i_in_valid && o_in_ready;

        n_state = r_state;
        n_k     = r_k;
        n_last  = r_last;
        unique case (r_state)
            bpc_pkg::ST_IDLE: begin
                if (load && i_sts.has_out) begin
                    n_state = bpc_pkg::ST_EMIT;
                    n_k     = '0;
                    n_last  = i_sts.last_idx;
                end
            end
            bpc_pkg::ST_EMIT: begin
                if (out_fire) begin
                    if (at_last) begin
                        if (load && i_sts.has_out) begin
                            n_k    = '0;
                            n_last = i_sts.last_idx;
                        end else begin
                            n_state = bpc_pkg::ST_IDLE;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = bpc_pkg::ST_IDLE;
        endcase

        o_cmd.load = load;
        o_cmd.step = out_fire;
        o_cmd.idx  = r_k;
    end

    assign o_out_valid = (r_state == bpc_pkg::ST_EMIT);
    assign o_out_last  = at_last;

`ifndef SYNTHESIS
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpc_pkg::ST_EMIT) |-> (r_k <= r_last))
        else $error("result counter past last index");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_sts.has_out) |=> (r_state == bpc_pkg::ST_EMIT && r_k == '0))
        else $error("loaded word did not start at its first result");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !at_last) |=> (r_k == $past(r_k) + 1'b1))
        else $error("result counter did not advance");
`endif

endmodule

>>> rtl/bitplane_row_to_chunky_pixels_top.sv
// Top level of the bitplane row to chunky pixel converter.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    source_byte[7:0], row_start
//  o_out     out  valid/ready    pixel_value[7:0], last_of_item, bad_format
//  i_cfg_*   in   i_cfg_we       i_cfg_idx[1:0], i_cfg_data[5:0]
//
// A word is taken, then its results go out one per cycle while o_out is ready:
// 8/depth for packed, 16 per completed planar group, 3 per RGB565 pixel,
// 1 otherwise. The next word is taken on the cycle the last result leaves;
// after a word with no result the block stays ready for the next word.
// Reset is synchronous; the plane byte store is not cleared.
// A stalled output holds the result counter and blocks input.
`timescale 1ns / 1ps
module bitplane_row_to_chunky_pixels_top #(
    parameter int MAX_PLANES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out
);

    bpc_pkg::t_dp_cmd cmd;
    bpc_pkg::t_dp_sts sts;
    logic             in_ready, out_valid, out_last;
    logic [7:0]       pixel_value;
    logic             bad_format;

    bpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_last  (out_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpc_datapath #(
        .MAX_PLANES (MAX_PLANES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_source_byte (i_in.source_byte),
        .i_row_start   (i_in.row_start),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_pixel_value (pixel_value),
        .o_bad_format  (bad_format)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.pixel_value  = pixel_value;
    assign o_out.last_of_item = out_last;
    assign o_out.bad_format   = bad_format;

endmodule

>>> sim/tb_bitplane_row_to_chunky_pixels_top.sv
// Self-checking testbench for the bitplane row to chunky pixel converter top level.
`timescale 1ns / 1ps
module tb_bitplane_row_to_chunky_pixels_top;

    localparam int MAX_PLANES   = 8;
    localparam int TARGET_WORDS = 230;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIR        = 24;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       bad;
    } t_pix;

    typedef struct packed {
        logic       cfg;        // rewrite all three registers before this word
        logic [5:0] depth;
        logic [1:0] layout;
        logic       inv;
        logic [7:0] src;
        logic       rs;
        logic       typed;      // single result given here, not by the predictor
        logic [7:0] exp_value;
        logic       exp_bad;
    } t_dir_row;

    // cfg depth layout inv src rs typed value bad
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{1'b0, 6'd1,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd1,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd1,  bpc_pkg::LAYOUT_PACKED, 1'b1, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd8,  bpc_pkg::LAYOUT_BYTE,   1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0},
        '{1'b0, 6'd8,  bpc_pkg::LAYOUT_BYTE,   1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{1'b1, 6'd2,  bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h1B, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd4,  bpc_pkg::LAYOUT_PACKED, 1'b1, 8'hF0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd8,  bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h80, 1'b1, 1'b1, 8'h80, 1'b0},
        '{1'b1, 6'd3,  bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h5A, 1'b1, 1'b1, 8'h00, 1'b1},
        '{1'b1, 6'd0,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'h12, 1'b1, 1'b1, 8'h00, 1'b1},
        '{1'b1, 6'd9,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'h34, 1'b0, 1'b1, 8'h00, 1'b1},
        '{1'b1, 6'd4,  bpc_pkg::LAYOUT_NONE,   1'b1, 8'h56, 1'b1, 1'b1, 8'h00, 1'b1},
        '{1'b1, 6'd63, bpc_pkg::LAYOUT_BYTE,   1'b0, 8'h78, 1'b0, 1'b1, 8'h00, 1'b1},
        '{1'b1, 6'd2,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd2,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd2,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd2,  bpc_pkg::LAYOUT_PLANAR, 1'b0, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd16, bpc_pkg::LAYOUT_NONE,   1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd16, bpc_pkg::LAYOUT_NONE,   1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b1, 6'd24, bpc_pkg::LAYOUT_BYTE,   1'b0, 8'h7E, 1'b1, 1'b1, 8'h7E, 1'b0},
        '{1'b1, 6'd32, bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h11, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 6'd32, bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h22, 1'b0, 1'b1, 8'h22, 1'b0},
        '{1'b0, 6'd32, bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h33, 1'b0, 1'b1, 8'h33, 1'b0},
        '{1'b0, 6'd32, bpc_pkg::LAYOUT_PACKED, 1'b0, 8'h44, 1'b0, 1'b1, 8'h44, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [5:0] i_cfg_data;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    bitplane_row_to_chunky_pixels_top #(
        .MAX_PLANES(MAX_PLANES)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // predictor state and register shadow
    logic [7:0] plane_store [16];
    logic [3:0] grp_pos;
    logic [5:0] cur_depth;
    logic [1:0] cur_layout;
    logic       cur_inv;
    t_pix       conv_res [16];
    int         conv_n;

    t_pix pixel_q [$];
    logic stall_en;
    int   err_cnt;
    int   words_sent;
    int   pixels_seen;
    int   settings_cnt;
    int   cycle_cnt;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bpc_pkg::CFG_PIXEL_DEPTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.source_byte = '0;
        in_ch.row_start = 1'b0;
        out_ch.ready = 1'b0;
        stall_en = 1'b1;
        err_cnt = 0;
        words_sent = 0;
        pixels_seen = 0;
        settings_cnt = 0;
        cycle_cnt = 0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pixel_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic format_bad(input logic [5:0] d, input logic [1:0] m);
        if (d == bpc_pkg::DEPTH_RGB565 || d == bpc_pkg::DEPTH_RGB24
            || d == bpc_pkg::DEPTH_XRGB32)
            return 1'b0;
        if (d < 6'd1 || d > 6'd8)
            return 1'b1;
        if (m == bpc_pkg::LAYOUT_NONE)
            return 1'b1;
        if (m == bpc_pkg::LAYOUT_PACKED)
            return !(d == 6'd1 || d == 6'd2 || d == 6'd4 || d == 6'd8);
        if (m == bpc_pkg::LAYOUT_PLANAR && d > 6'd1)
            return d > MAX_PLANES;
        return 1'b0;
    endfunction

    function automatic void add_pixel(input logic [7:0] v, input logic bad);
        conv_res[conv_n] = '{value: v, last: 1'b0, bad: bad};
        conv_n++;
    endfunction

    // Pixels caused by one source word; updates the group state.
    function automatic void convert_word(input logic [7:0] src, input logic rs);
        logic [7:0]  b;
        logic [7:0]  v;
        logic [15:0] w;
        int          d;
        int          pos;
        b = src;
        d = cur_depth;
        conv_n = 0;
        if (rs)
            grp_pos = '0;
        if (d == 1 && cur_inv)
            b = ~b;
        if (format_bad(cur_depth, cur_layout)) begin
            add_pixel(8'h00, 1'b1);
        end else if (d <= 8) begin
            if (cur_layout == bpc_pkg::LAYOUT_BYTE) begin
                add_pixel(b, 1'b0);
                grp_pos = '0;
            end else if (cur_layout == bpc_pkg::LAYOUT_PACKED || d == 1) begin
                for (int i = 0; i < 8 / d; i++)
                    add_pixel(8'((b >> (8 - d * (i + 1))) & ((1 << d) - 1)), 1'b0);
                grp_pos = '0;
            end else begin
                pos = grp_pos;
                plane_store[pos] = b;
                if (pos + 1 >= 2 * d) begin
                    // pixel i takes bit 15-i of each plane word, plane p into bit p
                    for (int i = 0; i < 16; i++) begin
                        v = '0;
                        for (int p = 0; p < d; p++) begin
                            w = {plane_store[2 * p], plane_store[2 * p + 1]};
                            v[p] = w[15 - i];
                        end
                        add_pixel(v, 1'b0);
                    end
                    grp_pos = '0;
                end else begin
                    grp_pos = 4'(pos + 1);
                end
            end
        end else if (cur_depth == bpc_pkg::DEPTH_RGB565) begin
            if (grp_pos == 4'd0) begin
                plane_store[0] = b;
                grp_pos = 4'd1;
            end else begin
                w = {plane_store[0], b};
                add_pixel({w[15:11], 3'b000}, 1'b0);
                add_pixel({w[10:5], 2'b00}, 1'b0);
                add_pixel({w[4:0], 3'b000}, 1'b0);
                grp_pos = '0;
            end
        end else if (cur_depth == bpc_pkg::DEPTH_RGB24) begin
            add_pixel(b, 1'b0);
            grp_pos = '0;
        end else begin
            // xRGB32: the pad byte at position 0 gives nothing
            if (grp_pos == 4'd0) begin
                grp_pos = 4'd1;
            end else begin
                add_pixel(b, 1'b0);
                grp_pos = (grp_pos >= 4'd3) ? 4'd0 : grp_pos + 4'd1;
            end
        end
        if (conv_n > 0)
            conv_res[conv_n - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 40)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Register writes only once the block has drained.
    task automatic apply_setting(input logic [5:0] d, input logic [1:0] m, input logic inv);
        in_ch.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= bpc_pkg::CFG_PIXEL_DEPTH;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_idx <= bpc_pkg::CFG_LAYOUT_MODE;
        i_cfg_data <= {4'b0000, m};
        @(posedge i_clk);
        i_cfg_idx <= bpc_pkg::CFG_INVERT_MONO;
        i_cfg_data <= {5'b00000, inv};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_depth = d;
        cur_layout = m;
        cur_inv = inv;
        settings_cnt++;
    endtask

    task automatic send_word(input logic [7:0] src, input logic rs, input logic typed,
                             input t_pix fixed);
        while (stall_en && $urandom_range(0, 99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.source_byte <= src;
        in_ch.row_start <= rs;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        convert_word(src, rs);
        if (typed) begin
            pixel_q.push_back(fixed);
        end else begin
            for (int k = 0; k < conv_n; k++)
                pixel_q.push_back(conv_res[k]);
        end
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= i_rst_n && (!stall_en || $urandom_range(0, 99) >= 38);
    end

    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h", out_ch.pixel_value));
            end else begin
                want = pixel_q.pop_front();
                if (out_ch.pixel_value !== want.value)
                    report_mismatch($sformatf("pixel_value %02h, expected %02h",
                                              out_ch.pixel_value, want.value));
                if (out_ch.last_of_item !== want.last)
                    report_mismatch($sformatf("last_of_item %b, expected %b",
                                              out_ch.last_of_item, want.last));
                if (out_ch.bad_format !== want.bad)
                    report_mismatch($sformatf("bad_format %b, expected %b",
                                              out_ch.bad_format, want.bad));
            end
        end
    end

    initial begin
        t_dir_row   row;
        logic [5:0] d;
        logic [1:0] m;
        logic       inv;
        logic       rs;
        logic [7:0] b;
        int         phase;
        int         n;
        int         unit;
        int         seq_pos;

        for (int i = 0; i < 16; i++)
            plane_store[i] = '0;
        grp_pos = '0;
        cur_depth = 6'd1;
        cur_layout = bpc_pkg::LAYOUT_PLANAR;
        cur_inv = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; the first rows run on the reset settings
        for (int r = 0; r < N_DIR; r++) begin
            row = DIR_ROWS[r];
            if (row.cfg)
                apply_setting(row.depth, row.layout, row.inv);
            send_word(row.src, row.rs, row.typed, '{row.exp_value, 1'b1, row.exp_bad});
        end

        // random phases, each on its own register setting
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            inv = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 8))
                0: begin d = 6'($urandom_range(2, 8)); m = bpc_pkg::LAYOUT_PLANAR; end
                1: begin d = 6'd8; m = bpc_pkg::LAYOUT_PLANAR; end
                2: begin
                    d = 6'd1;
                    m = $urandom_range(0, 1) ? bpc_pkg::LAYOUT_PLANAR
                                             : bpc_pkg::LAYOUT_PACKED;
                end
                3: begin d = 6'(1 << $urandom_range(0, 3)); m = bpc_pkg::LAYOUT_PACKED; end
                4: begin d = 6'($urandom_range(1, 8)); m = bpc_pkg::LAYOUT_BYTE; end
                5: begin d = bpc_pkg::DEPTH_RGB565; m = 2'($urandom_range(0, 3)); end
                6: begin d = bpc_pkg::DEPTH_RGB24; m = 2'($urandom_range(0, 3)); end
                7: begin d = bpc_pkg::DEPTH_XRGB32; m = 2'($urandom_range(0, 3)); end
                default: begin
                    d = 6'($urandom_range(0, 63));
                    m = 2'($urandom_range(0, 3));
                end
            endcase
            stall_en = !(phase >= 3 && phase <= 5);
            apply_setting(d, m, inv);

            if (format_bad(d, m))
                unit = 1;
            else if (d == bpc_pkg::DEPTH_RGB565)
                unit = 2;
            else if (d == bpc_pkg::DEPTH_XRGB32)
                unit = 4;
            else if (d > 6'd1 && d <= 6'd8 && m == bpc_pkg::LAYOUT_PLANAR)
                unit = 2 * d;
            else
                unit = 1;
            n = (unit >= 8) ? unit * $urandom_range(1, 2) : $urandom_range(12, 24);

            // mostly whole groups; now and then a row restarts mid-group
            seq_pos = 0;
            for (int k = 0; k < n; k++) begin
                rs = (k == 0) || (seq_pos == 0 && $urandom_range(0, 3) == 0)
                     || ($urandom_range(0, 19) == 0);
                case ($urandom_range(0, 7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_word(b, rs, 1'b0, '0);
                if (rs)
                    seq_pos = 0;
                seq_pos = (seq_pos + 1) % unit;
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d source words under %0d register settings, %0d pixel words out.",
                 words_sent, settings_cnt + 1, pixels_seen);
        $display("Formats: planar 1 to 8 planes, packed, byte, RGB565, RGB24, xRGB32, bad pairs.");
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
